/* rtl/sixwma_pkg.sv */
// Shared types, constants and control bundles for the six-axis weighted moving average.
`default_nettype none

package sixwma_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int AXES           = 6;
  localparam int AXIS_BITS      = $clog2(AXES);
  localparam int LEN_BITS       = 7;
  localparam int LEN_MAX        = (1 << LEN_BITS) - 1;
  localparam int DEF_MAX_WINDOW = 64;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = LEN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHTED_MODE = CFG_IDX_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one history row: lane i holds component i
  typedef logic [AXES-1:0][SAMPLE_BITS-1:0] row_t;

  typedef struct packed {
    logic    first_of_series;
    sample_t comp_0;
    sample_t comp_1;
    sample_t comp_2;
    sample_t comp_3;
    sample_t comp_4;
    sample_t comp_5;
  } in_beat_t;

  typedef struct packed {
    sample_t avg_0;
    sample_t avg_1;
    sample_t avg_2;
    sample_t avg_3;
    sample_t avg_4;
    sample_t avg_5;
  } out_beat_t;

  typedef struct packed {
    logic clear;  // zero all lane sums
    logic add;    // a history row is on rdata this cycle
    logic keep;   // row belongs to the series, else add zero
  } acc_ctl_t;

  typedef struct packed {
    logic load;   // take numerator, start a division
    logic step;   // one quotient bit
  } div_ctl_t;

endpackage

`default_nettype wire

/* rtl/sixwma_hist.sv */
// Sample history memory: one row of six components per entry, registered read.
`default_nettype none

module sixwma_hist #(
  parameter int MAX_WINDOW = 64,
  parameter int AW         = 6
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [AW-1:0]         waddr,
  input  sixwma_pkg::row_t      wdata,
  input  wire                   re,
  input  wire  [AW-1:0]         raddr,
  output sixwma_pkg::row_t      rdata
);
  import sixwma_pkg::*;

  row_t mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sixwma_acc.sv */
// Six-lane running accumulator: plain sum and linearly weighted sum per axis.
`default_nettype none

module sixwma_acc #(
  parameter int PW = 23,
  parameter int NW = 28
) (
  input  wire                                       clk,
  input  sixwma_pkg::acc_ctl_t                      ctl,
  input  sixwma_pkg::row_t                          row,
  output logic [sixwma_pkg::AXES-1:0][PW-1:0]       psum,
  output logic [sixwma_pkg::AXES-1:0][NW-1:0]       wsum
);
  import sixwma_pkg::*;

  logic signed [PW-1:0] x_ext  [AXES];
  logic signed [PW-1:0] p_next [AXES];
  logic signed [NW-1:0] w_next [AXES];

  // Walking newest to oldest and adding the running plain sum into the
  // weighted sum each step gives the newest sample weight L, oldest 1.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      x_ext[a]  = ctl.keep ? PW'($signed(row[a])) : '0;
      p_next[a] = $signed(psum[a]) + x_ext[a];
      w_next[a] = $signed(wsum[a]) + NW'(p_next[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (ctl.clear) begin
        psum[a] <= '0;
        wsum[a] <= '0;
      end else if (ctl.add) begin
        psum[a] <= p_next[a];
        wsum[a] <= w_next[a];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sixwma_div.sv */
// Bit-serial signed divider: magnitude restoring division, one quotient bit per step.
`default_nettype none

module sixwma_div #(
  parameter int NW = 28,
  parameter int DB = 12
) (
  input  wire                                   clk,
  input  sixwma_pkg::div_ctl_t                  ctl,
  input  wire  [NW-1:0]                         numer,
  input  wire  [DB-1:0]                         divisor,
  output logic [sixwma_pkg::SAMPLE_BITS-1:0]    quot
);
  import sixwma_pkg::*;

  localparam int Q = SAMPLE_BITS;

  logic [DB-1:0] rem;
  logic [Q-1:0]  low;
  logic          neg;

  logic [NW-1:0] mag;
  logic [DB:0]   sh;
  logic [DB:0]   diff;
  logic          ge;

  // |quotient| stays below 2^Q, so the upper DB bits of the magnitude
  // already sit below the divisor and only Q steps are needed.
  always_comb begin
    mag  = numer[NW-1] ? NW'(-numer) : numer;
    sh   = {rem, low[Q-1]};
    diff = sh - {1'b0, divisor};
    ge   = sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= numer[NW-1];
      rem <= mag[NW-1 -: DB];
      low <= mag[Q-1:0];
    end else if (ctl.step) begin
      rem <= ge ? diff[DB-1:0] : sh[DB-1:0];
      low <= {low[Q-2:0], ge};
    end
  end

  assign quot = neg ? Q'(-low) : low;

endmodule

`default_nettype wire

/* rtl/six_axis_weighted_moving_average.sv */
// Six-axis moving average, plain or linearly weighted, over a sample history memory.
// One item at a time: the next input beat is taken once the result sits in the output
//   register, even if it is still stalled there.
// Per item: one history read per window slot, then a 16-step serial divide per axis.
// Reset (rst, synchronous): window_length 1, plain mode, empty series; memory left as is.
`default_nettype none

module six_axis_weighted_moving_average #(
  parameter int MAX_WINDOW = sixwma_pkg::DEF_MAX_WINDOW
) (
  input  wire                                    clk,
  input  wire                                    rst,
  // sample channel
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  sixwma_pkg::in_beat_t                   in_data,
  // result channel
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output sixwma_pkg::out_beat_t                  out_data,
  // register writes
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [sixwma_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire  [sixwma_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sixwma_pkg::*;

  // Longest window actually usable: capped by storage and by the length field.
  localparam int EFF_MAX  = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
  localparam int KB       = $clog2(EFF_MAX + 1);
  localparam int TRI_MAX  = EFF_MAX * (EFF_MAX + 1) / 2;
  localparam int DB       = $clog2(TRI_MAX + 1);
  localparam int PW       = SAMPLE_BITS + KB;
  localparam int NW       = SAMPLE_BITS + DB;
  localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FB       = $clog2(MAX_WINDOW + 1);
  localparam int QB       = $clog2(SAMPLE_BITS);
  localparam int PB       = 2 * KB + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;  // one history read per window slot
  localparam logic [2:0] ST_DRAIN = 3'd2;  // last read lands in the accumulator
  localparam logic [2:0] ST_LOAD  = 3'd3;  // pick axis numerator, arm divider
  localparam logic [2:0] ST_DIV   = 3'd4;  // serial quotient bits
  localparam logic [2:0] ST_STORE = 3'd5;  // save quotient, next axis
  localparam logic [2:0] ST_OUT   = 3'd6;  // hand result to the output register

  // configuration
  logic [LEN_BITS-1:0] window_length;
  logic                weighted_mode;

  // series bookkeeping
  logic [AW-1:0]  write_slot;
  logic [FB-1:0]  fill_count;

  // per-item working registers
  logic [2:0]           state;
  logic [AW-1:0]        rptr;
  logic [KB-1:0]        k;
  logic [KB-1:0]        len_r;
  logic [KB-1:0]        valid_r;
  logic                 mode_r;
  logic [DB-1:0]        divisor;
  logic [AXIS_BITS-1:0] axis;
  logic [QB-1:0]        bit_cnt;
  logic                 rd_live;
  logic                 rd_keep;
  row_t                 res;

  // accept-time values
  logic                 accept;
  logic [KB-1:0]        len_eff;
  logic [FB-1:0]        fill_next;
  logic [KB-1:0]        valid_next;
  logic [PB-1:0]        len_ext;
  logic [PB-1:0]        tri_prod;
  logic [AW-1:0]        write_slot_next;
  logic [AW-1:0]        rptr_next;
  row_t                 in_row;

  // datapath hookups
  acc_ctl_t                   acc_ctl;
  div_ctl_t                   div_ctl;
  row_t                       rd_row;
  logic [AXES-1:0][PW-1:0]    psum;
  logic [AXES-1:0][NW-1:0]    wsum;
  logic [NW-1:0]              numer;
  logic [SAMPLE_BITS-1:0]     quot;
  logic                       out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    // zero length acts as one, anything past storage saturates
    if (window_length == '0) begin
      len_eff = KB'(1);
    end else if (32'(window_length) > 32'(EFF_MAX)) begin
      len_eff = KB'(EFF_MAX);
    end else begin
      len_eff = KB'(window_length);
    end

    if (in_data.first_of_series) begin
      fill_next = FB'(1);
    end else if (32'(fill_count) < 32'(MAX_WINDOW)) begin
      fill_next = fill_count + 1'b1;
    end else begin
      fill_next = fill_count;
    end

    valid_next = (32'(fill_next) < 32'(len_eff)) ? KB'(fill_next) : len_eff;

    // L(L+1)/2 for the weighted divisor
    len_ext  = PB'(len_eff);
    tri_prod = len_ext * (len_ext + 1'b1);

    write_slot_next = (32'(write_slot) == MAX_WINDOW - 1) ? '0 : write_slot + 1'b1;
    rptr_next       = (rptr == '0) ? AW'(MAX_WINDOW - 1) : rptr - 1'b1;

    in_row[0] = in_data.comp_0;
    in_row[1] = in_data.comp_1;
    in_row[2] = in_data.comp_2;
    in_row[3] = in_data.comp_3;
    in_row[4] = in_data.comp_4;
    in_row[5] = in_data.comp_5;
  end

  // Slots past the series start are still read, but they enter as zero.
  always_comb begin
    acc_ctl.clear = accept;
    acc_ctl.add   = rd_live;
    acc_ctl.keep  = rd_keep;
    div_ctl.load  = (state == ST_LOAD);
    div_ctl.step  = (state == ST_DIV);
    numer = mode_r ? wsum[axis] : NW'($signed(psum[axis]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_BITS'(1);
      weighted_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[LEN_BITS-1:0];
        REG_WEIGHTED_MODE: weighted_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      rd_live    <= 1'b0;
    end else begin
      rd_live <= (state == ST_ACC);
      rd_keep <= (k < valid_r);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rptr       <= write_slot;
            write_slot <= write_slot_next;
            fill_count <= fill_next;
            len_r      <= len_eff;
            valid_r    <= valid_next;
            mode_r     <= weighted_mode;
            divisor    <= weighted_mode ? DB'(tri_prod >> 1) : DB'(len_eff);
            k          <= '0;
            axis       <= '0;
            state      <= ST_ACC;
          end
        end
        ST_ACC: begin
          rptr <= rptr_next;
          k    <= k + 1'b1;
          if (k == len_r - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          bit_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == QB'(SAMPLE_BITS - 1)) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          res[axis] <= quot;
          if (axis == AXIS_BITS'(AXES - 1)) begin
            state <= ST_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: holds a finished beat while the sequencer moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid      <= 1'b1;
      out_data.avg_0 <= res[0];
      out_data.avg_1 <= res[1];
      out_data.avg_2 <= res[2];
      out_data.avg_3 <= res[3];
      out_data.avg_4 <= res[4];
      out_data.avg_5 <= res[5];
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  sixwma_hist #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata (in_row),
    .re    (state == ST_ACC),
    .raddr (rptr),
    .rdata (rd_row)
  );

  sixwma_acc #(
    .PW (PW),
    .NW (NW)
  ) u_acc (
    .clk  (clk),
    .ctl  (acc_ctl),
    .row  (rd_row),
    .psum (psum),
    .wsum (wsum)
  );

  sixwma_div #(
    .NW (NW),
    .DB (DB)
  ) u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .numer   (numer),
    .divisor (divisor),
    .quot    (quot)
  );

endmodule

`default_nettype wire
